/* src/ipscr_pkg.sv */
// Package for the IPv4 address scrambler: shared constants, types and the
// controller-to-datapath command and status structs. No dependencies.
`default_nettype none

package ipscr_pkg;

  // Number of chain rounds when two or more address bytes are free.
  localparam int unsigned ROUNDS = 100;
  localparam int unsigned RND_W  = $clog2(ROUNDS + 1);

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned TBL_AW  = 8;
  localparam int unsigned NBYTES  = 4;
  localparam int unsigned BIDX_W  = 2;
  localparam int unsigned CFG_IW  = 3;
  localparam int unsigned CFG_DW  = 8;
  localparam int unsigned PLEN_W  = 3;

  // Configuration register indexes.
  localparam logic [CFG_IW-1:0] REG_PREFIX_LEN = 3'd0;
  localparam logic [CFG_IW-1:0] REG_FIXED0     = 3'd1;
  localparam logic [CFG_IW-1:0] REG_FIXED1     = 3'd2;
  localparam logic [CFG_IW-1:0] REG_FIXED2     = 3'd3;
  localparam logic [CFG_IW-1:0] REG_FIXED3     = 3'd4;

  // Opcodes of an input transaction.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_GEN  = 1'b1;

  // Effective prefix lengths with special handling.
  localparam logic [PLEN_W-1:0] PLEN_ONE_FREE = 3'd3;
  localparam logic [PLEN_W-1:0] PLEN_FIXED    = 3'd4;

  typedef struct packed {
    logic                mem_we;   // write table entry from the input transaction
    logic                capture;  // build the starting address bytes
    logic                lookup;   // issue one table read of the chain
    logic                first;    // running byte is zero for this lookup
    logic [BIDX_W-1:0]   cur_idx;  // address byte feeding this lookup
    logic                wb_en;    // store the previous lookup result
    logic [BIDX_W-1:0]   wb_idx;   // address byte that receives it
    logic                push;     // move the address into the output register
  } ipscr_cmd_t;

  typedef struct packed {
    logic [PLEN_W-1:0]   p_eff;    // prefix length clamped to four
    logic                out_free; // output register can take a new address
  } ipscr_stat_t;

endpackage

`default_nettype wire

/* src/ipscr_if.sv */
// Handshake interfaces for the input and result channels of the scrambler.
// Depends on ipscr_pkg for the field widths.
`default_nettype none

interface ipscr_in_if
  import ipscr_pkg::*;
;
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [TBL_AW-1:0]   entry_index;
  logic [BYTE_W-1:0]   entry_value;
  logic [ADDR_W-1:0]   counter;

  modport source (output valid, opcode, entry_index, entry_value, counter,
                  input ready);
  modport sink   (input valid, opcode, entry_index, entry_value, counter,
                  output ready);
endinterface

interface ipscr_out_if
  import ipscr_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   address;

  modport source (output valid, address, input ready);
  modport sink   (input valid, address, output ready);
endinterface

`default_nettype wire

/* src/ipscr_ctrl.sv */
// Controller state machine of the scrambler: sequences table loads, the
// lookup chain and the output push. Depends on ipscr_pkg.
`default_nettype none

module ipscr_ctrl
  import ipscr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_opcode,
  output logic             in_ready,
  input  wire ipscr_stat_t stat,
  output ipscr_cmd_t       cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_RUN    = 4'b0010,
    ST_WB     = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [BIDX_W-1:0] cur_r, cur_nxt;
  logic [BIDX_W-1:0] prev_r, prev_nxt;
  logic [BIDX_W-1:0] start_r, start_nxt;
  logic              first_r, first_nxt;
  logic              single_r, single_nxt;
  logic [RND_W-1:0]  round_r, round_nxt;
  logic [RND_W-1:0]  round_last;
  logic              accept;

  assign in_ready   = (state_r == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign round_last = single_r ? '0 : RND_W'(ROUNDS - 1);

  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    prev_nxt   = prev_r;
    start_nxt  = start_r;
    first_nxt  = first_r;
    single_nxt = single_r;
    round_nxt  = round_r;
    cmd        = '0;
    cmd.cur_idx = cur_r;
    cmd.wb_idx  = prev_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_opcode == OP_LOAD) begin
            cmd.mem_we = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            round_nxt   = '0;
            first_nxt   = 1'b1;
            // A fully fixed prefix needs no table access at all.
            if (stat.p_eff == PLEN_FIXED) begin
              state_nxt = ST_FINISH;
            end else begin
              state_nxt  = ST_RUN;
              single_nxt = (stat.p_eff == PLEN_ONE_FREE);
              start_nxt  = stat.p_eff[BIDX_W-1:0];
              cur_nxt    = stat.p_eff[BIDX_W-1:0];
            end
          end
        end
      end
      ST_RUN: begin
        cmd.lookup = 1'b1;
        cmd.first  = first_r;
        cmd.wb_en  = !first_r;
        first_nxt  = 1'b0;
        prev_nxt   = cur_r;
        if (cur_r == BIDX_W'(NBYTES - 1)) begin
          cur_nxt = start_r;
          if (round_r == round_last) begin
            state_nxt = ST_WB;
          end else begin
            round_nxt = round_r + RND_W'(1);
          end
        end else begin
          cur_nxt = cur_r + BIDX_W'(1);
        end
      end
      ST_WB: begin
        cmd.wb_en = 1'b1;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cur_r    <= '0;
      prev_r   <= '0;
      start_r  <= '0;
      first_r  <= 1'b0;
      single_r <= 1'b0;
      round_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      cur_r    <= cur_nxt;
      prev_r   <= prev_nxt;
      start_r  <= start_nxt;
      first_r  <= first_nxt;
      single_r <= single_nxt;
      round_r  <= round_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/ipscr_dp.sv */
// Datapath of the scrambler: configuration registers, the permutation table
// memory, the four address byte registers and the output register.
// Depends on ipscr_pkg.
`default_nettype none

module ipscr_dp
  import ipscr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_wdata,
  input  wire logic [TBL_AW-1:0] in_entry_index,
  input  wire logic [BYTE_W-1:0] in_entry_value,
  input  wire logic [ADDR_W-1:0] in_counter,
  input  wire ipscr_cmd_t        cmd,
  output ipscr_stat_t            stat,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [ADDR_W-1:0]      out_address
);

  logic [PLEN_W-1:0] prefix_r;
  logic [BYTE_W-1:0] fixed_r [NBYTES];
  logic [BYTE_W-1:0] byte_r  [NBYTES];
  logic [BYTE_W-1:0] init_byte [NBYTES];
  logic [BYTE_W-1:0] perm_mem [2**TBL_AW];
  logic [BYTE_W-1:0] rdata_r;
  logic [TBL_AW-1:0] rd_addr;
  logic [BYTE_W-1:0] chain_in;
  logic              out_valid_r;
  logic [ADDR_W-1:0] out_addr_r;

  // Prefix lengths five to seven behave as a fully fixed address.
  assign stat.p_eff    = (prefix_r > PLEN_FIXED) ? PLEN_FIXED : prefix_r;
  assign stat.out_free = !out_valid_r || out_ready;

  // Fixed bytes first, then counter bytes from the low end.
  always_comb begin
    logic [BIDX_W-1:0] j;
    for (int i = 0; i < NBYTES; i++) begin
      j = BIDX_W'(i) - stat.p_eff[BIDX_W-1:0];
      if (PLEN_W'(i) < stat.p_eff) begin
        init_byte[i] = fixed_r[i];
      end else begin
        init_byte[i] = in_counter[{j, 3'b000} +: BYTE_W];
      end
    end
  end

  assign chain_in = cmd.first ? '0 : rdata_r;
  assign rd_addr  = chain_in ^ byte_r[cmd.cur_idx];

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      perm_mem[in_entry_index] <= in_entry_value;
    end
    if (cmd.lookup) begin
      rdata_r <= perm_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      for (int i = 0; i < NBYTES; i++) begin
        byte_r[i] <= init_byte[i];
      end
    end else if (cmd.wb_en) begin
      byte_r[cmd.wb_idx] <= rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r <= '0;
      for (int i = 0; i < NBYTES; i++) begin
        fixed_r[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PREFIX_LEN: prefix_r   <= cfg_wdata[PLEN_W-1:0];
        REG_FIXED0:     fixed_r[0] <= cfg_wdata;
        REG_FIXED1:     fixed_r[1] <= cfg_wdata;
        REG_FIXED2:     fixed_r[2] <= cfg_wdata;
        REG_FIXED3:     fixed_r[3] <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_addr_r <= {byte_r[0], byte_r[1], byte_r[2], byte_r[3]};
    end
  end

  assign out_valid   = out_valid_r;
  assign out_address = out_addr_r;

endmodule

`default_nettype wire

/* src/ipv4_address_scrambler_unit.sv */
// Top level of the IPv4 address scrambler: joins the controller and the
// datapath. Depends on ipscr_pkg, ipscr_in_if and ipscr_out_if.
//
// Usage. The input channel carries one transaction per item. A load
// transaction (opcode 0) writes one byte of the 256-entry permutation table
// and returns nothing; the input stays ready after it. A generate transaction
// (opcode 1) returns one address on the result channel. Software must load
// every table entry that a generate can touch before issuing it.
// A generate runs the lookup chain: a fully fixed prefix skips it, prefix
// length 3 runs one round over its one free byte, and shorter prefixes run
// 100 rounds over the free bytes. Each lookup depends on the previous one and
// the table has a single read port with a registered output, so one lookup
// issues per cycle.
// One generate is in flight at a time; the next transaction is taken once
// the address has moved into the output register.
// The output register holds a finished address while the receiver stalls,
// so the next transaction can be accepted and processed meanwhile; a second
// result waits in the address byte registers, with the input not ready,
// until the output register frees.
// Reset (rst_n low at a clock edge) clears the configuration registers to
// zero and empties the output register; the table contents are not cleared.
// Configuration writes are taken at any edge with cfg_we high but must only
// be issued while the block is idle.
`default_nettype none

module ipv4_address_scrambler_unit
  import ipscr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_wdata,
  ipscr_in_if.sink               in_ch,
  ipscr_out_if.source            out_ch
);

  ipscr_cmd_t  cmd;
  ipscr_stat_t stat;

  // The controller owns the input handshake and the sequencing.
  ipscr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_opcode (in_ch.opcode),
    .in_ready  (in_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds every register of the payload and the output stage.
  ipscr_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_entry_index (in_ch.entry_index),
    .in_entry_value (in_ch.entry_value),
    .in_counter     (in_ch.counter),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_address    (out_ch.address)
  );

endmodule

`default_nettype wire
